/* hdl/ptc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and constants of the playback time controller.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int MarkersDefault = 8;

    // Item function codes.
    typedef enum logic [2:0] {
        FUNC_TICK   = 3'd0,
        FUNC_START  = 3'd1,
        FUNC_STOP   = 3'd2,
        FUNC_SEEK   = 3'd3,
        FUNC_MARKER = 3'd4
    } func_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_DURATION = 3'd0,
        REG_SPEED    = 3'd1,
        REG_LOOP     = 3'd2,
        REG_BEGIN    = 3'd3,
        REG_END      = 3'd4
    } reg_idx_t;

    // Loop modes.
    localparam logic [1:0] LOOP_NONE   = 2'd0;
    localparam logic [1:0] LOOP_REPEAT = 2'd1;

    localparam logic signed [31:0] END_NEVER = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_MAP,
        ST_MARK,
        ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // latch item and step magnitude, clear the result flags
        logic step;      // apply the item: step, and end test for a tick
        logic div_start; // start the serial divide
        logic map;       // finish the local time
        logic mark;      // compute marker hits
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_map;  // item changes the local time
        logic is_tick;   // item is a running tick
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

/* hdl/playback_time_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// playback_time_controller
// Fixed-point playback clock with clamp, repeat and ping-pong loop modes.
// ----------------------------------------------------------------------------
// Channel | Signals                                         | Dir
// in      | in_valid/in_ready, func, dt, resume, time_value  | in
// out     | out_valid/out_ready, absolute_time ... hits      | out
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data         | in
//
// A running tick, start or seek passes through the step state, the 32-step
// serial divide of the absolute time by duration, and the map, mark and
// output states before its result is registered. Stop, add-marker, unused
// codes and a tick while stopped go from the step state straight to output.
// Reset clears all time state; the marker store holds no reset value.
// The result sits in an output register; the next item is accepted once the
// sequencer is back in idle, even while that result still waits for ready.
// ----------------------------------------------------------------------------
module playback_time_controller
#(
    parameter int MARKERS = ptc_pkg::MarkersDefault
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         func,
    input  wire logic [23:0]        dt,
    input  wire logic               resume,
    input  wire logic signed [31:0] time_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      absolute_time,
    output logic [30:0]             local_time,
    output logic                    playing,
    output logic                    started,
    output logic                    ended,
    output logic [7:0]              marker_hits,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    ptc_pkg::cmd_t  cmd;
    ptc_pkg::stat_t stat;
    logic busy;
    logic res_load;
    logic in_fire;
    logic out_free;

    logic [30:0]        duration_reg;
    logic signed [15:0] speed_reg;
    logic [1:0]         loop_reg;
    logic signed [31:0] begin_reg;
    logic signed [31:0] end_reg;

    logic signed [31:0] r_abs;
    logic [30:0]        r_local;
    logic               r_playing;
    logic               r_started;
    logic               r_ended;
    logic [7:0]         r_hits;
    logic               ovalid_reg;

    assign in_ready  = ~busy;
    assign in_fire   = in_valid & in_ready;
    assign out_free  = ~ovalid_reg | out_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= 31'd65536;
            speed_reg    <= 16'sd256;
            loop_reg     <= 2'd0;
            begin_reg    <= 32'sd0;
            end_reg      <= 32'sd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ptc_pkg::REG_DURATION: duration_reg <= cfg_data[30:0];
                ptc_pkg::REG_SPEED:    speed_reg    <= cfg_data[15:0];
                ptc_pkg::REG_LOOP:     loop_reg     <= cfg_data[1:0];
                ptc_pkg::REG_BEGIN:    begin_reg    <= cfg_data;
                ptc_pkg::REG_END:      end_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ptc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .res_load (res_load)
    );

    ptc_dpath #(.MARKERS(MARKERS)) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .dt         (dt),
        .resume     (resume),
        .time_value (time_value),
        .duration   (duration_reg),
        .speed      (speed_reg),
        .loop_mode  (loop_reg),
        .begin_time (begin_reg),
        .end_time   (end_reg),
        .r_abs      (r_abs),
        .r_local    (r_local),
        .r_playing  (r_playing),
        .r_started  (r_started),
        .r_ended    (r_ended),
        .r_hits     (r_hits)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            absolute_time <= r_abs;
            local_time    <= r_local;
            playing       <= r_playing;
            started       <= r_started;
            ended         <= r_ended;
            marker_hits   <= r_hits;
        end
    end

    assign out_valid = ovalid_reg;

endmodule
`default_nettype wire

/* hdl/ptc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_ctrl
// Sequencer: walks an item through step, optional divide/map/mark, and output.
// ----------------------------------------------------------------------------
module ptc_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_free,
    input  wire ptc_pkg::stat_t  stat,
    output ptc_pkg::cmd_t        cmd,
    output logic                 busy,
    output logic                 res_load
);

    ptc_pkg::state_t state_reg;
    ptc_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ptc_pkg::ST_STEP;
                end
            end
            ptc_pkg::ST_STEP:
            begin
                state_next = stat.need_map ? ptc_pkg::ST_DIV : ptc_pkg::ST_OUT;
            end
            ptc_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ptc_pkg::ST_MAP;
                end
            end
            ptc_pkg::ST_MAP:
            begin
                state_next = ptc_pkg::ST_MARK;
            end
            ptc_pkg::ST_MARK:
            begin
                state_next = ptc_pkg::ST_OUT;
            end
            ptc_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ptc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        busy     = 1'b1;
        res_load = 1'b0;
        case (state_reg)
            ptc_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = in_fire;
            end
            ptc_pkg::ST_STEP:
            begin
                cmd.step      = 1'b1;
                cmd.div_start = stat.need_map;
            end
            ptc_pkg::ST_MAP:
            begin
                cmd.map = 1'b1;
            end
            ptc_pkg::ST_MARK:
            begin
                cmd.mark = 1'b1;
            end
            ptc_pkg::ST_OUT:
            begin
                res_load = out_free;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // The divider is only started from the step phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> state_reg == ptc_pkg::ST_STEP)
        else $error("divide start outside step phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ptc_pkg::ST_STEP)
        else $error("item load did not enter step phase");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> state_reg == ptc_pkg::ST_IDLE)
        else $error("result load did not return to idle");

endmodule
`default_nettype wire

/* hdl/ptc_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_dpath
// Datapath: time state, step multiply, serial divider by duration, local
// time mapping and marker store with hit compares.
// ----------------------------------------------------------------------------
module ptc_dpath
#(
    parameter int MARKERS = ptc_pkg::MarkersDefault
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptc_pkg::cmd_t      cmd,
    output ptc_pkg::stat_t          stat,
    input  wire logic [2:0]         func,
    input  wire logic [23:0]        dt,
    input  wire logic               resume,
    input  wire logic signed [31:0] time_value,
    input  wire logic [30:0]        duration,
    input  wire logic signed [15:0] speed,
    input  wire logic [1:0]         loop_mode,
    input  wire logic signed [31:0] begin_time,
    input  wire logic signed [31:0] end_time,
    output logic signed [31:0]      r_abs,
    output logic [30:0]             r_local,
    output logic                    r_playing,
    output logic                    r_started,
    output logic                    r_ended,
    output logic [7:0]              r_hits
);

    localparam int CW = $clog2(MARKERS + 1);
    localparam int IW = (MARKERS > 1) ? $clog2(MARKERS) : 1;
    localparam int HN = (MARKERS < 8) ? MARKERS : 8;

    // Item latch.
    logic [2:0]         func_reg;
    logic [31:0]        mag_reg;
    logic               resume_reg;
    logic signed [31:0] tv_reg;

    // Time state.
    logic signed [31:0] abs_reg;
    logic [30:0]        lnow_reg;
    logic [30:0]        lprev_reg;
    logic               run_reg;
    logic               tick_reg;
    logic signed [1:0]  dir_reg;
    logic               started_reg;
    logic               ended_reg;
    logic [7:0]         hits_reg;
    logic [CW-1:0]      mcount_reg;
    logic signed [31:0] mstore [MARKERS];

    // Divider.
    logic [31:0] dq_reg;
    logic [31:0] dr_reg;
    logic [5:0]  dcnt_reg;
    logic        dbusy_reg;
    logic        dneg_reg;
    logic        ddone_reg;

    // Tick step: magnitude and saturated new time.
    logic [15:0]        spd_mag;
    logic [39:0]        prod;
    logic signed [1:0]  ssgn;
    logic signed [1:0]  s;
    logic signed [33:0] na_wide;
    logic signed [31:0] na_sat;
    logic signed [33:0] diff;
    logic               end_hit;
    logic signed [31:0] start_pt;

    // The step magnitude is formed when the item is latched.
    assign spd_mag = speed[15] ? 16'(-speed) : speed;
    assign prod    = 40'(spd_mag) * 40'(dt);
    assign ssgn    = (speed == 16'sd0) ? 2'sd0 : (speed[15] ? -2'sd1 : 2'sd1);
    assign s       = 2'(dir_reg * ssgn);
    always_comb
    begin
        na_wide = 34'(abs_reg);
        if (s == 2'sd1)
        begin
            na_wide = 34'(abs_reg) + $signed({2'b00, mag_reg});
        end
        else if (s == -2'sd1)
        begin
            na_wide = 34'(abs_reg) - $signed({2'b00, mag_reg});
        end
        if (na_wide > 34'sh0_7FFF_FFFF)
        begin
            na_sat = 32'sh7FFF_FFFF;
        end
        else if (na_wide < -34'sh0_8000_0000)
        begin
            na_sat = 32'sh8000_0000;
        end
        else
        begin
            na_sat = na_wide[31:0];
        end
        diff    = 34'(na_sat) - 34'(end_time);
        end_hit = (end_time != ptc_pkg::END_NEVER) &&
                  ((s == 2'sd1 && diff > 34'sd0) || (s == -2'sd1 && diff < 34'sd0));
        start_pt = resume_reg ? abs_reg : begin_time;
    end

    logic is_tick;
    assign is_tick = (func_reg == ptc_pkg::FUNC_TICK) && run_reg;
    assign stat.is_tick  = is_tick;
    assign stat.need_map = is_tick || func_reg == ptc_pkg::FUNC_START ||
                           func_reg == ptc_pkg::FUNC_SEEK;
    assign stat.div_done = ddone_reg;

    // Divide operand magnitude of the new absolute time.
    logic signed [31:0] abs_after;
    logic [31:0]        amag;
    always_comb
    begin
        abs_after = abs_reg;
        case (func_reg)
            ptc_pkg::FUNC_TICK:
            begin
                // A tick while stopped leaves the time alone.
                if (run_reg)
                begin
                    abs_after = end_hit ? end_time : na_sat;
                end
            end
            ptc_pkg::FUNC_START: abs_after = start_pt;
            ptc_pkg::FUNC_SEEK:  abs_after = tv_reg;
            default:             abs_after = abs_reg;
        endcase
        amag = abs_after[31] ? 32'(-abs_after) : 32'(abs_after);
    end

    // Restoring divider step.
    logic [32:0] trial;
    assign trial = {dr_reg, dq_reg[31]} - {2'b00, duration};

    // Local time from quotient and remainder.
    logic [30:0] lmap;
    logic [30:0] dmr;
    assign dmr = duration - dr_reg[30:0];
    always_comb
    begin
        if (duration == 31'd0)
        begin
            lmap = 31'd0;
        end
        else if (loop_mode == ptc_pkg::LOOP_NONE)
        begin
            if (abs_reg[31])
            begin
                lmap = 31'd0;
            end
            else if (abs_reg[30:0] > duration)
            begin
                lmap = duration;
            end
            else
            begin
                lmap = abs_reg[30:0];
            end
        end
        else if (loop_mode == ptc_pkg::LOOP_REPEAT)
        begin
            lmap = dneg_reg ? dmr : dr_reg[30:0];
        end
        else
        begin
            lmap = dq_reg[0] ? dmr : dr_reg[30:0];
        end
    end

    // Marker hit compares.
    logic [30:0] lo;
    logic [30:0] hi;
    logic [7:0]  hits;
    assign lo = (lprev_reg < lnow_reg) ? lprev_reg : lnow_reg;
    assign hi = (lprev_reg < lnow_reg) ? lnow_reg : lprev_reg;
    always_comb
    begin
        hits = '0;
        for (int i = 0; i < HN; i++)
        begin
            if (CW'(i) < mcount_reg &&
                mstore[i] >= $signed({1'b0, lo}) && mstore[i] <= $signed({1'b0, hi}))
            begin
                hits[i] = 1'b1;
            end
        end
    end

    // Marker store.
    always_ff @(posedge clk)
    begin
        if (cmd.load == 1'b0 && func_reg == ptc_pkg::FUNC_MARKER && cmd.step &&
            mcount_reg < CW'(MARKERS))
        begin
            mstore[mcount_reg[IW-1:0]] <= tv_reg;
        end
    end

    // Item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            mag_reg    <= prod[39:8];
            resume_reg <= resume;
            tv_reg     <= time_value;
        end
    end

    // State and divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_reg     <= '0;
            lnow_reg    <= '0;
            lprev_reg   <= '0;
            run_reg     <= 1'b0;
            tick_reg    <= 1'b0;
            dir_reg     <= 2'sd1;
            mcount_reg  <= '0;
            started_reg <= 1'b0;
            ended_reg   <= 1'b0;
            hits_reg    <= '0;
            dq_reg      <= '0;
            dr_reg      <= '0;
            dcnt_reg    <= '0;
            dbusy_reg   <= 1'b0;
            dneg_reg    <= 1'b0;
            ddone_reg   <= 1'b0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.load)
            begin
                started_reg <= 1'b0;
                ended_reg   <= 1'b0;
                hits_reg    <= '0;
            end
            if (cmd.step)
            begin
                abs_reg  <= abs_after;
                tick_reg <= is_tick;
                case (func_reg)
                    ptc_pkg::FUNC_TICK:
                    begin
                        if (run_reg && end_hit)
                        begin
                            run_reg   <= 1'b0;
                            ended_reg <= 1'b1;
                        end
                    end
                    ptc_pkg::FUNC_START:
                    begin
                        run_reg     <= 1'b1;
                        started_reg <= 1'b1;
                        dir_reg     <= (end_time > start_pt) ? 2'sd1 :
                                       ((end_time < start_pt) ? -2'sd1 : 2'sd0);
                    end
                    ptc_pkg::FUNC_STOP:
                    begin
                        run_reg <= 1'b0;
                    end
                    ptc_pkg::FUNC_MARKER:
                    begin
                        if (mcount_reg < CW'(MARKERS))
                        begin
                            mcount_reg <= mcount_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.div_start)
            begin
                dq_reg    <= amag;
                dr_reg    <= '0;
                dcnt_reg  <= 6'd32;
                dbusy_reg <= 1'b1;
                dneg_reg  <= ~(abs_after > 32'sd0);
            end
            else if (dbusy_reg)
            begin
                if (trial[32])
                begin
                    dr_reg <= {dr_reg[30:0], dq_reg[31]};
                    dq_reg <= {dq_reg[30:0], 1'b0};
                end
                else
                begin
                    dr_reg <= trial[31:0];
                    dq_reg <= {dq_reg[30:0], 1'b1};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd1)
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
            if (cmd.map)
            begin
                lnow_reg  <= lmap;
                lprev_reg <= tick_reg ? lnow_reg : lmap;
            end
            if (cmd.mark && tick_reg)
            begin
                hits_reg <= hits;
            end
        end
    end

    // Tick flag uses run state before the step; keep it once stepped.
    assign r_abs     = abs_reg;
    assign r_local   = lnow_reg;
    assign r_playing = run_reg;
    assign r_started = started_reg;
    assign r_ended   = ended_reg;
    assign r_hits    = hits_reg;

    // A finished divide leaves a remainder below the duration.
    assert property (@(posedge clk) disable iff (!rst_n)
        ddone_reg |-> (duration == 31'd0) || (dr_reg < {1'b0, duration}))
        else $error("divider remainder out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        mcount_reg <= CW'(MARKERS))
        else $error("marker count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> dbusy_reg)
        else $error("divider did not start");

endmodule
`default_nettype wire

/* tb/playback_time_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playback_time_controller_tb
// Self-checking bench for the playback time controller. A directed table of
// items covers reset state, start, end stop, markers, seek, stop and unused
// codes. Random phases then run start/tick sequences under several register
// settings. Every result is checked against an in-bench model or a typed row.
// ----------------------------------------------------------------------------
module playback_time_controller_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic signed [31:0] abs_t;
        logic [30:0]        loc_t;
        logic               play;
        logic               start;
        logic               stop_hit;
        logic [7:0]         hits;
    } play_result_t;

    // One row of the directed table.
    typedef struct {
        logic [2:0]         fn;
        logic [23:0]        step_dt;
        logic               keep;
        logic signed [31:0] tval;
        bit                 typed;
        play_result_t       want;
    } item_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         func;
    logic [23:0]        dt;
    logic               resume;
    logic signed [31:0] time_value;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] absolute_time;
    logic [30:0]        local_time;
    logic               playing;
    logic               started;
    logic               ended;
    logic [7:0]         marker_hits;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    playback_time_controller dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .dt(dt),
        .resume(resume), .time_value(time_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .absolute_time(absolute_time), .local_time(local_time),
        .playing(playing), .started(started), .ended(ended),
        .marker_hits(marker_hits),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model copy of registers and timeline state.
    longint m_duration, m_speed, m_begin, m_end;
    int unsigned m_loop;
    longint m_abs, m_local_now, m_local_prev;
    bit m_run;
    int m_dir;
    longint m_marks [ptc_pkg::MarkersDefault];
    int unsigned m_mark_count;

    play_result_t pending_results [$];
    int send_idle_pct, recv_idle_pct;
    int mismatches, results_seen, items_sent;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Map an absolute time onto one pass according to the loop mode.
    function automatic longint pass_position(longint a);
        longint q, r;
        if (m_duration <= 0)
            return 0;
        if (m_loop == ptc_pkg::LOOP_NONE)
            return (a < 0) ? 0 : ((a > m_duration) ? m_duration : a);
        q = ((a > 0) ? a : -a) / m_duration;
        r = ((a > 0) ? a : -a) % m_duration;
        if (m_loop == ptc_pkg::LOOP_REPEAT)
            return (a > 0) ? r : m_duration - r;
        return q[0] ? m_duration - r : r;
    endfunction

    task automatic model_reset();
        m_duration = 65536; m_speed = 256; m_loop = 0;
        m_begin = 0; m_end = 65536;
        m_abs = 0; m_local_now = 0; m_local_prev = 0;
        m_run = 0; m_dir = 1; m_mark_count = 0;
    endtask

    // Apply one item to the timeline and return the result it produces.
    function automatic play_result_t advance_timeline(logic [2:0] fn, logic [23:0] sdt,
                                                       logic keep, logic signed [31:0] tv);
        play_result_t res;
        longint mag, na, lo, hi;
        int s;
        res = '0;
        case (fn)
            ptc_pkg::FUNC_TICK:
                if (m_run)
                begin
                    mag = (((m_speed < 0) ? -m_speed : m_speed) * longint'(sdt)) >>> 8;
                    s = m_dir * sign_of(m_speed);
                    na = m_abs + s * mag;
                    if (na > 64'sd2147483647) na = 64'sd2147483647;
                    if (na < -64'sd2147483648) na = -64'sd2147483648;
                    m_abs = na;
                    if (m_end != 64'sd2147483647 && (m_abs - m_end) * s > 0)
                    begin
                        m_abs = m_end;
                        m_run = 0;
                        res.stop_hit = 1'b1;
                    end
                    m_local_prev = m_local_now;
                    m_local_now = pass_position(m_abs);
                    lo = (m_local_prev < m_local_now) ? m_local_prev : m_local_now;
                    hi = (m_local_prev < m_local_now) ? m_local_now : m_local_prev;
                    for (int i = 0; i < m_mark_count; i++)
                        if (m_marks[i] >= lo && m_marks[i] <= hi)
                            res.hits[i] = 1'b1;
                end
            ptc_pkg::FUNC_START:
            begin
                if (!keep)
                    m_abs = m_begin;
                m_run = 1;
                m_dir = sign_of(m_end - m_abs);
                m_local_now = pass_position(m_abs);
                m_local_prev = m_local_now;
                res.start = 1'b1;
            end
            ptc_pkg::FUNC_STOP:
                m_run = 0;
            ptc_pkg::FUNC_SEEK:
            begin
                m_abs = tv;
                m_local_now = pass_position(m_abs);
                m_local_prev = m_local_now;
            end
            ptc_pkg::FUNC_MARKER:
                if (m_mark_count < ptc_pkg::MarkersDefault)
                begin
                    m_marks[m_mark_count] = tv;
                    m_mark_count++;
                end
            default: ;
        endcase
        res.abs_t = m_abs[31:0];
        res.loc_t = m_local_now[30:0];
        res.play  = m_run;
        return res;
    endfunction

    // Drive one item; the expectation is queued at the accepting edge.
    task automatic send_item(logic [2:0] fn, logic [23:0] sdt, logic keep,
                             logic signed [31:0] tv, bit typed, play_result_t want);
        play_result_t res;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= fn; dt <= sdt; resume <= keep; time_value <= tv;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = advance_timeline(fn, sdt, keep, tv);
        pending_results.insert(pending_results.size(), typed ? want : res);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Write one register and mirror it in the model; the caller waits for quiet.
    task automatic write_reg(ptc_pkg::reg_idx_t idx, logic [31:0] value);
        cfg_index <= idx; cfg_data <= value; cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ptc_pkg::REG_DURATION: m_duration = value[30:0];
            ptc_pkg::REG_SPEED:    m_speed = longint'($signed(value[15:0]));
            ptc_pkg::REG_LOOP:     m_loop = value[1:0];
            ptc_pkg::REG_BEGIN:    m_begin = longint'($signed(value));
            ptc_pkg::REG_END:      m_end = longint'($signed(value));
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(logic [31:0] dur, logic [15:0] spd, logic [1:0] mode,
                                 logic [31:0] bt, logic [31:0] et);
        wait_results_done();
        repeat (45) @(negedge clk);
        write_reg(ptc_pkg::REG_DURATION, dur);
        write_reg(ptc_pkg::REG_SPEED, {16'd0, spd});
        write_reg(ptc_pkg::REG_LOOP, {30'd0, mode});
        write_reg(ptc_pkg::REG_BEGIN, bt);
        write_reg(ptc_pkg::REG_END, et);
    endtask

    // Random phase: mostly ticks, with starts, seeks, stops, markers and unused codes.
    task automatic random_phase(int count, logic [31:0] dur);
        int n, pick;
        logic [23:0] sdt;
        play_result_t none;
        none = '0;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_item(ptc_pkg::FUNC_START, 24'($urandom), 1'($urandom_range(1)),
                          32'($urandom), 1'b0, none);
            else if (pick < 12)
                send_item(ptc_pkg::FUNC_SEEK, 24'($urandom), 1'($urandom_range(1)),
                          (pick < 10) ? 32'($urandom) : 32'($urandom_range(dur)),
                          1'b0, none);
            else if (pick < 14)
                send_item(ptc_pkg::FUNC_STOP, 24'($urandom), 1'($urandom_range(1)),
                          32'($urandom), 1'b0, none);
            else if (pick < 16)
                send_item(ptc_pkg::FUNC_MARKER, 24'($urandom), 1'($urandom_range(1)),
                          32'($urandom_range(dur)), 1'b0, none);
            else if (pick < 18)
                send_item(3'($urandom_range(7, 5)), 24'($urandom), 1'($urandom_range(1)),
                          32'($urandom), 1'b0, none);
            else
            begin
                sdt = (pick < 30) ? 24'($urandom) : 24'($urandom_range(32768));
                send_item(ptc_pkg::FUNC_TICK, sdt, 1'($urandom_range(1)),
                          32'($urandom), 1'b0, none);
            end
            n++;
        end
    endtask

    // Directed table: typed expectations only for reset state, first start and end stop.
    item_row_t dir_rows [$];

    task automatic add_row(logic [2:0] fn, logic [23:0] sdt, logic keep,
                           logic signed [31:0] tv, bit typed, play_result_t want);
        item_row_t row;
        row.fn = fn; row.step_dt = sdt; row.keep = keep; row.tval = tv;
        row.typed = typed; row.want = want;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        play_result_t got, exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{absolute_time, local_time, playing, started, ended, marker_hits};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 results_seen, exp_r, got);
                end
            end
        end
    end

    // Receiver back pressure.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("playback_time_controller_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        play_result_t w;
        in_valid = 1'b0; func = ptc_pkg::FUNC_TICK; dt = '0; resume = 1'b0;
        time_value = '0;
        cfg_valid = 1'b0; cfg_index = ptc_pkg::REG_DURATION; cfg_data = '0;
        mismatches = 0; results_seen = 0; items_sent = 0;
        send_idle_pct = 13; recv_idle_pct = 54;
        model_reset();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Tick while stopped after reset, then start from begin_time.
        w = '0;
        add_row(ptc_pkg::FUNC_TICK, 24'h00_8000, 1'b0, 32'sd0, 1'b1, w);
        w = '{32'sd0, 31'd0, 1'b1, 1'b1, 1'b0, 8'd0};
        add_row(ptc_pkg::FUNC_START, 24'd0, 1'b0, 32'sd0, 1'b1, w);
        add_row(ptc_pkg::FUNC_TICK, 24'h00_8000, 1'b0, 32'sd0, 1'b0, w);
        // Largest step crosses the end time and stops there.
        w = '{32'sd65536, 31'd65536, 1'b0, 1'b0, 1'b1, 8'd0};
        add_row(ptc_pkg::FUNC_TICK, 24'hFF_FFFF, 1'b0, 32'sd0, 1'b1, w);
        // Nine markers: the last one overflows the store.
        for (int i = 0; i < 9; i++)
            add_row(ptc_pkg::FUNC_MARKER, 24'd0, 1'b0, 32'sd8192 * i, 1'b0, w);
        add_row(ptc_pkg::FUNC_SEEK, 24'd0, 1'b0, 32'sh8000_0000, 1'b0, w);
        add_row(ptc_pkg::FUNC_SEEK, 24'd0, 1'b0, 32'sh7FFF_FFFF, 1'b0, w);
        add_row(ptc_pkg::FUNC_SEEK, 24'd0, 1'b0, 32'sd0, 1'b0, w);
        add_row(ptc_pkg::FUNC_START, 24'd0, 1'b1, 32'sd0, 1'b0, w);
        add_row(ptc_pkg::FUNC_TICK, 24'h00_4000, 1'b0, 32'sh7FFF_FFFF, 1'b0, w);
        add_row(ptc_pkg::FUNC_TICK, 24'h00_6000, 1'b1, 32'sh8000_0000, 1'b0, w);
        add_row(3'd5, 24'hFF_FFFF, 1'b1, 32'shFFFF_FFFF, 1'b0, w);
        add_row(3'd6, 24'd1, 1'b0, 32'sd1, 1'b0, w);
        add_row(3'd7, 24'd0, 1'b1, 32'sd0, 1'b0, w);
        add_row(ptc_pkg::FUNC_STOP, 24'd0, 1'b0, 32'sd0, 1'b0, w);
        add_row(ptc_pkg::FUNC_TICK, 24'h00_1000, 1'b0, 32'sd0, 1'b0, w);
        foreach (dir_rows[i])
            send_item(dir_rows[i].fn, dir_rows[i].step_dt, dir_rows[i].keep,
                      dir_rows[i].tval, dir_rows[i].typed, dir_rows[i].want);

        // Random phases over several register settings, including extremes.
        set_registers(32'h0004_0000, 16'h0180, 2'd1, 32'hFFFE_0000, 32'h7FFF_FFFF);
        random_phase(100, 32'h0004_0000);
        send_idle_pct = 54; recv_idle_pct = 13;
        set_registers(32'h0003_0000, 16'hFF00, 2'd2, 32'h0010_0000, 32'hFFF0_0000);
        random_phase(60, 32'h0003_0000);
        // Hold off until the block has delivered everything.
        wait_results_done();
        random_phase(40, 32'h0003_0000);
        set_registers(32'h0000_0001, 16'h7FFF, 2'd3, 32'h8000_0000, 32'h7FFF_FFFE);
        random_phase(80, 32'h0000_0001);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_registers(32'h7FFF_FFFF, 16'h8000, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        random_phase(80, 32'h7FFF_FFFF);
        set_registers(32'h0000_0000, 16'h0000, 2'd1, 32'h0000_0000, 32'h0001_0000);
        random_phase(40, 32'h0000_0000);
        set_registers(32'h0002_0000, 16'h0100, 2'd0, 32'h0000_0000, 32'h0008_0000);
        random_phase(200, 32'h0002_0000);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d items and %0d results over six register settings,",
                 items_sent, results_seen);
        $display("all loop modes, speed and time extremes, markers and end stops.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("playback_time_controller_tb: done, clean");
        else
            $display("playback_time_controller_tb: done, errors");
        $finish;
    end

endmodule
